[hdl/drag_coefficient_root_finder_defines.svh]
// Assertion macros shared by the root finder RTL.
`ifndef DRAG_COEFFICIENT_ROOT_FINDER_DEFINES_SVH
`define DRAG_COEFFICIENT_ROOT_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DRC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/drc_pkg.sv]
// Types, constants and codes shared by the drag coefficient root finder.
package drc_pkg;

    localparam int ITERATION_CAP_DEFAULT = 64;

    localparam logic [30:0] APEX_GOAL_RST     = 31'd780288;
    localparam logic [15:0] CONV_LIMIT_RST    = 16'd256;
    localparam logic [6:0]  MAX_ITER_RST      = 7'd20;
    localparam logic [15:0] GRAVITY_RST       = 16'd2511;
    localparam logic [31:0] INITIAL_K_RST     = 32'd429497;

    localparam logic [31:0] SEED_DEFAULT = 32'd42949673;  // 0.01 in Q0.32
    localparam logic [63:0] LN2_Q32      = 64'd2977044472;
    localparam logic [47:0] DS_MAX       = 48'h8000_0000_0000;
    localparam logic [15:0] COS_ONE      = 16'h8000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_APEX_GOAL     = 3'd0,
        REG_CONV_LIMIT    = 3'd1,
        REG_MAX_ITER      = 3'd2,
        REG_GRAVITY       = 3'd3,
        REG_INITIAL_K     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [30:0] apex_goal;
        logic [15:0] conv_limit;
        logic [6:0]  max_iter;
        logic [15:0] gravity;
    } cfg_t;

    typedef enum logic [2:0] {
        MD_ZK, MD_X, MD_L2, MD_V, MD_PROJ, MD_TGT, MD_DQ, MD_DELTA
    } md_sel_t;

    // what follows the product: a full divide or a fixed power-of-two scale
    typedef enum logic [1:0] {
        MP_DIV, MP_SHR15, MP_SHR32
    } md_post_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_GEFF, OP_Y, OP_LN_SHIFT, OP_LN_INIT, OP_SQ, OP_FOLD,
        OP_DS, OP_PROJ, OP_TGT, OP_ERR, OP_KE, OP_DEN, OP_DN, OP_NEWK, OP_HALVE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    md_start;
        md_sel_t md_sel;
    } cmd_t;

    typedef struct packed {
        logic md_done;
        logic dk_zero;
        logic norm_done;
        logic sq_last;
        logic go_on;
        logic dn_pos;
    } status_t;

    typedef enum logic [4:0] {
        CS_IDLE, CS_GEFF, CS_DIST, CS_X_WAIT, CS_NORM, CS_SQ, CS_FOLD, CS_L2,
        CS_L2_WAIT, CS_V_WAIT, CS_PROJ, CS_PROJ_WAIT, CS_TGT_WAIT, CS_ERR,
        CS_CHECK, CS_KE, CS_DEN, CS_DQ, CS_DQ_WAIT, CS_DN, CS_DELTA_WAIT,
        CS_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MS_IDLE, MS_MUL, MS_CHECK, MS_DIV
    } md_state_t;

endpackage

[hdl/drc_muldiv.sv]
// Sequential floor(a*b/c) unit: 64x64 product in four partial products, then restoring divide or shift.
module drc_muldiv import drc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  md_post_t    post,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] c,
    output logic        done,
    output logic [63:0] q
);

    md_state_t state_reg, state_next;
    md_post_t  post_reg, post_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  rr, diff;
    logic         ge, sat;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp     = a_half * b_half;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0:       pp_sh = {64'd0, pp};
            2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
            default:    pp_sh = {pp, 64'd0};
        endcase
    end

    // remainder lives in the upper half of acc, dividend bits shift out of the lower half
    assign rr   = {acc_reg[127:64], acc_reg[63]};
    assign ge   = rr >= {1'b0, c_reg};
    assign diff = rr - {1'b0, c_reg};
    assign sat  = (c_reg == 64'd0) || (acc_reg[127:64] >= c_reg);

    always_comb begin
        state_next = state_reg;
        post_next  = post_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            MS_IDLE: begin
                if (start) begin
                    a_next     = a;
                    b_next     = b;
                    c_next     = c;
                    post_next  = post;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = MS_MUL;
                end
            end
            MS_MUL: begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3) begin
                    state_next = MS_CHECK;
                end
            end
            MS_CHECK: begin
                // power-of-two divisors never saturate here
                if (post_reg == MP_SHR15) begin
                    q_next     = acc_reg[78:15];
                    done_next  = 1'b1;
                    state_next = MS_IDLE;
                end else if (post_reg == MP_SHR32) begin
                    q_next     = acc_reg[95:32];
                    done_next  = 1'b1;
                    state_next = MS_IDLE;
                end else if (sat) begin
                    q_next     = '1;
                    done_next  = 1'b1;
                    state_next = MS_IDLE;
                end else begin
                    q_next     = '0;
                    cnt_next   = 6'd63;
                    state_next = MS_DIV;
                end
            end
            MS_DIV: begin
                acc_next = {(ge ? diff[63:0] : rr[63:0]), acc_reg[62:0], 1'b0};
                q_next   = {q_reg[62:0], ge};
                if (cnt_reg == 6'd0) begin
                    done_next  = 1'b1;
                    state_next = MS_IDLE;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        post_reg <= post_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

[hdl/drc_ctrl.sv]
// Sequencer for projection, target and Newton iterations of the root finder.
module drc_ctrl import drc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output cmd_t    cmd,
    input  status_t status
);

    ctrl_state_t state_reg, state_next;
    logic iter_reg, iter_next;      // 0: distance feeds the projection, 1: Newton loop
    logic out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd.op         = OP_NONE;
        cmd.md_start   = 1'b0;
        cmd.md_sel     = MD_ZK;
        unique case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = CS_GEFF;
                end
            end
            CS_GEFF: begin
                cmd.op     = OP_GEFF;
                iter_next  = 1'b0;
                state_next = CS_DIST;
            end
            CS_DIST: begin
                cmd.md_start = 1'b1;
                if (status.dk_zero) begin
                    cmd.md_sel = MD_ZK;
                    state_next = CS_V_WAIT;
                end else begin
                    cmd.md_sel = MD_X;
                    state_next = CS_X_WAIT;
                end
            end
            CS_X_WAIT: begin
                if (status.md_done) begin
                    cmd.op     = OP_Y;
                    state_next = CS_NORM;
                end
            end
            CS_NORM: begin
                if (status.norm_done) begin
                    cmd.op     = OP_LN_INIT;
                    state_next = CS_SQ;
                end else begin
                    cmd.op = OP_LN_SHIFT;
                end
            end
            CS_SQ: begin
                cmd.op     = OP_SQ;
                state_next = CS_FOLD;
            end
            CS_FOLD: begin
                cmd.op     = OP_FOLD;
                state_next = status.sq_last ? CS_L2 : CS_SQ;
            end
            CS_L2: begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = MD_L2;
                state_next   = CS_L2_WAIT;
            end
            CS_L2_WAIT: begin
                if (status.md_done) begin
                    cmd.md_start = 1'b1;
                    cmd.md_sel   = MD_V;
                    state_next   = CS_V_WAIT;
                end
            end
            CS_V_WAIT: begin
                if (status.md_done) begin
                    cmd.op     = OP_DS;
                    state_next = iter_reg ? CS_ERR : CS_PROJ;
                end
            end
            CS_PROJ: begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = MD_PROJ;
                state_next   = CS_PROJ_WAIT;
            end
            CS_PROJ_WAIT: begin
                if (status.md_done) begin
                    cmd.op       = OP_PROJ;
                    cmd.md_start = 1'b1;
                    cmd.md_sel   = MD_TGT;
                    state_next   = CS_TGT_WAIT;
                end
            end
            CS_TGT_WAIT: begin
                if (status.md_done) begin
                    cmd.op     = OP_TGT;
                    iter_next  = 1'b1;
                    state_next = CS_DIST;
                end
            end
            CS_ERR: begin
                cmd.op     = OP_ERR;
                state_next = CS_CHECK;
            end
            CS_CHECK: begin
                state_next = status.go_on ? CS_KE : CS_FINISH;
            end
            CS_KE: begin
                cmd.op     = OP_KE;
                state_next = CS_DEN;
            end
            CS_DEN: begin
                cmd.op     = OP_DEN;
                state_next = CS_DQ;
            end
            CS_DQ: begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = MD_DQ;
                state_next   = CS_DQ_WAIT;
            end
            CS_DQ_WAIT: begin
                if (status.md_done) begin
                    cmd.op     = OP_DN;
                    state_next = CS_DN;
                end
            end
            CS_DN: begin
                if (status.dn_pos) begin
                    cmd.md_start = 1'b1;
                    cmd.md_sel   = MD_DELTA;
                    state_next   = CS_DELTA_WAIT;
                end else begin
                    cmd.op     = OP_HALVE;
                    state_next = CS_DIST;
                end
            end
            CS_DELTA_WAIT: begin
                if (status.md_done) begin
                    cmd.op     = OP_NEWK;
                    state_next = CS_DIST;
                end
            end
            CS_FINISH: begin
                // output register must be free before it is overwritten
                if (!out_valid_reg || m_ready) begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            iter_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == CS_IDLE);
    assign m_valid = out_valid_reg;

endmodule

[hdl/drc_dp.sv]
// Datapath: operand registers, log squaring loop, Newton update and result registers.
module drc_dp import drc_pkg::*; #(
    parameter int ITERATION_CAP = ITERATION_CAP_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    input  cfg_t               cfg,
    input  logic [31:0]        s_eps,
    input  logic [15:0]        s_cos_theta,
    input  logic signed [31:0] s_altitude,
    input  logic [31:0]        s_current_k,
    output status_t            status,
    output logic signed [32:0] m_k_error,
    output logic signed [31:0] m_projected_apogee,
    output logic               m_converged
);

    localparam int CW = $clog2(ITERATION_CAP + 1);

    logic [31:0]        e_reg, kc_reg, dk_reg, k_reg, m_reg, frac_reg, target_k_reg;
    logic [15:0]        c_reg;
    logic signed [31:0] z_reg, proj_reg;
    logic [30:0]        geff_reg;
    logic [63:0]        y_reg, sq_reg, den_reg;
    logic [4:0]         s_reg, i_reg;
    logic [47:0]        ds_reg;
    logic signed [48:0] tgt_reg, dn_reg;
    logic signed [49:0] err_reg;
    logic [CW-1:0]      it_reg, cap;
    logic signed [32:0] k_error_reg;
    logic signed [31:0] proj_out_reg;
    logic               conv_reg;

    logic        md_done;
    logic [63:0] md_q, md_a, md_b, md_c;
    md_post_t    md_post;

    logic [15:0]        g_nz, cos_in;
    logic [31:0]        geff_prod;
    logic signed [32:0] tdiff;
    logic [32:0]        tmag;
    logic signed [49:0] err_neg, err_val, psum;
    logic [48:0]        err_mag;
    logic [4:0]         pexp;
    logic [63:0]        l2, y_val;
    logic [32:0]        sq_t;
    logic [47:0]        q_clamp;
    logic signed [48:0] tgt_val, dn_val;
    logic [31:0]        k_new, k_seed, tk;
    logic               conv;
    logic signed [31:0] proj_sat;

    drc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .post    (md_post),
        .a       (md_a),
        .b       (md_b),
        .c       (md_c),
        .done    (md_done),
        .q       (md_q)
    );

    assign g_nz   = (cfg.gravity == 16'd0) ? 16'd1 : cfg.gravity;
    assign cos_in = (s_cos_theta == 16'd0) ? 16'd1 :
                    ((s_cos_theta > COS_ONE) ? COS_ONE : s_cos_theta);
    assign geff_prod = c_reg * g_nz;

    assign tdiff = $signed({2'b00, cfg.apex_goal}) - $signed({z_reg[31], z_reg});
    assign tmag  = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);

    assign err_neg = -err_reg;
    assign err_mag = err_reg[49] ? err_neg[48:0] : err_reg[48:0];

    assign pexp = 5'd31 - s_reg;
    assign l2   = {27'd0, pexp, frac_reg};

    // x saturates at 2^63 before the log argument 1 + x is formed
    assign y_val   = (md_q > 64'h8000_0000_0000_0000) ? 64'h8000_0001_0000_0000
                                                       : md_q + 64'h1_0000_0000;
    assign sq_t    = sq_reg[63:31];
    assign q_clamp = (md_q > {16'd0, DS_MAX}) ? DS_MAX : md_q[47:0];

    assign tgt_val = tdiff[32] ? -$signed({1'b0, md_q[47:0]}) : $signed({1'b0, md_q[47:0]});
    assign dn_val  = $signed({1'b0, ds_reg}) - $signed({1'b0, q_clamp});
    assign err_val = $signed({2'b00, ds_reg}) - $signed({tgt_reg[48], tgt_reg});
    assign psum    = $signed({{18{z_reg[31]}}, z_reg}) + $signed({2'b00, md_q[47:0]});

    always_comb begin
        if (psum > 50'sd2147483647) begin
            proj_sat = 32'sh7FFF_FFFF;
        end else if (psum < -50'sd2147483648) begin
            proj_sat = 32'sh8000_0000;
        end else begin
            proj_sat = psum[31:0];
        end
    end

    always_comb begin
        if (int'(cfg.max_iter) > ITERATION_CAP) begin
            cap = CW'(ITERATION_CAP);
        end else begin
            cap = CW'(cfg.max_iter);
        end
    end

    // Newton update: grow on overshoot, shrink on undershoot, halve when the step fails
    always_comb begin
        if (!err_reg[49]) begin
            k_new = (md_q > {32'd0, ~k_reg}) ? 32'hFFFF_FFFF : k_reg + md_q[31:0];
        end else if (md_q < {32'd0, k_reg}) begin
            k_new = k_reg - md_q[31:0];
        end else begin
            k_new = k_reg >> 1;
        end
    end

    assign k_seed = (target_k_reg == 32'd0) ? SEED_DEFAULT : target_k_reg;
    assign conv   = (it_reg != cap);
    assign tk     = conv ? k_reg : target_k_reg;

    always_comb begin
        md_a    = '0;
        md_b    = '0;
        md_c    = '0;
        md_post = MP_DIV;
        unique case (cmd.md_sel)
            MD_ZK: begin
                md_a = {32'd0, e_reg};
                md_b = 64'd1 << 23;
                md_c = {33'd0, geff_reg};
            end
            MD_X: begin
                md_a = {32'd0, dk_reg};
                md_b = {17'd0, e_reg, 15'd0};
                md_c = {33'd0, geff_reg};
            end
            MD_L2: begin
                md_a    = l2;
                md_b    = LN2_Q32;
                md_post = MP_SHR32;
            end
            MD_V: begin
                md_a = md_q;
                md_b = 64'd256;
                md_c = {32'd0, dk_reg};
            end
            MD_PROJ: begin
                md_a    = {48'd0, c_reg};
                md_b    = {16'd0, ds_reg};
                md_post = MP_SHR15;
            end
            MD_TGT: begin
                md_a = {31'd0, tmag};
                md_b = 64'd32768;
                md_c = {48'd0, c_reg};
            end
            MD_DQ: begin
                md_a = {32'd0, e_reg};
                md_b = 64'd1 << 39;
                md_c = den_reg;
            end
            MD_DELTA: begin
                md_a = {32'd0, k_reg};
                md_b = {15'd0, err_mag};
                md_c = {15'd0, dn_reg[48:0]};
            end
            default: begin
                md_a = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_k_reg <= INITIAL_K_RST;
        end else if (cmd.op == OP_TGT) begin
            target_k_reg <= k_seed;
        end else if (cmd.op == OP_FINISH) begin
            target_k_reg <= tk;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                e_reg  <= s_eps;
                c_reg  <= cos_in;
                z_reg  <= s_altitude;
                kc_reg <= s_current_k;
            end
            OP_GEFF: begin
                geff_reg <= geff_prod[30:0];
                dk_reg   <= kc_reg;
            end
            OP_Y: begin
                y_reg <= y_val;
                s_reg <= '0;
            end
            OP_LN_SHIFT: begin
                y_reg <= {y_reg[62:0], 1'b0};
                s_reg <= s_reg + 5'd1;
            end
            OP_LN_INIT: begin
                m_reg    <= y_reg[63:32];
                frac_reg <= '0;
                i_reg    <= '0;
            end
            OP_SQ: begin
                sq_reg <= m_reg * m_reg;
            end
            OP_FOLD: begin
                m_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                frac_reg <= {frac_reg[30:0], sq_t[32]};
                i_reg    <= i_reg + 5'd1;
            end
            OP_DS: begin
                ds_reg <= q_clamp;
            end
            OP_PROJ: begin
                proj_reg <= proj_sat;
            end
            OP_TGT: begin
                tgt_reg <= tgt_val;
                k_reg   <= k_seed;
                dk_reg  <= k_seed;
                it_reg  <= '0;
            end
            OP_ERR: begin
                err_reg <= err_val;
            end
            OP_KE: begin
                sq_reg <= k_reg * e_reg;
            end
            OP_DEN: begin
                den_reg <= {17'd0, geff_reg, 16'd0} + {1'b0, sq_reg[63:1]};
            end
            OP_DN: begin
                dn_reg <= dn_val;
            end
            OP_NEWK: begin
                k_reg  <= k_new;
                dk_reg <= k_new;
                it_reg <= it_reg + CW'(1);
            end
            OP_HALVE: begin
                k_reg  <= k_reg >> 1;
                dk_reg <= k_reg >> 1;
                it_reg <= it_reg + CW'(1);
            end
            OP_FINISH: begin
                k_error_reg  <= $signed({1'b0, tk}) - $signed({1'b0, kc_reg});
                proj_out_reg <= proj_reg;
                conv_reg     <= conv;
            end
            default: begin
                conv_reg <= conv_reg;
            end
        endcase
    end

    assign status.md_done   = md_done;
    assign status.dk_zero   = (dk_reg == 32'd0);
    assign status.norm_done = y_reg[63] || (s_reg == 5'd31);
    assign status.sq_last   = (i_reg == 5'd31);
    assign status.go_on     = (err_mag > {33'd0, cfg.conv_limit}) && (it_reg < cap);
    assign status.dn_pos    = !dn_reg[48] && (dn_reg != 49'sd0);

    assign m_k_error          = k_error_reg;
    assign m_projected_apogee = proj_out_reg;
    assign m_converged        = conv_reg;

endmodule

[hdl/drag_coefficient_root_finder.sv]
// Top level of the drag coefficient root finder: configuration registers, sequencer, datapath.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    eps, cos_theta, altitude, current_k
//  m_        out        m_valid / m_ready    k_error, projected_apogee, converged
//  cfg_      in         cfg_we               cfg_index, cfg_data
//
// One transaction at a time. A true divide in the shared multiply-divide unit forms
// 4 partial products and then runs 64 restoring steps, a power-of-two scale a shift; the
// log normalises its argument by shifts and then squares once for each of 32 fraction bits.
// target_k resets to the initial_k reset value; writes to initial_k never reach it.
// A result waits in the output register while the next runs; that one stalls at finish.
`include "drag_coefficient_root_finder_defines.svh"

module drag_coefficient_root_finder import drc_pkg::*; #(
    parameter int ITERATION_CAP = ITERATION_CAP_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_eps,
    input  logic [15:0]           s_cos_theta,
    input  logic signed [31:0]    s_altitude,
    input  logic [31:0]           s_current_k,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [32:0]    m_k_error,
    output logic signed [31:0]    m_projected_apogee,
    output logic                  m_converged,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.apex_goal     <= APEX_GOAL_RST;
            cfg_reg.conv_limit    <= CONV_LIMIT_RST;
            cfg_reg.max_iter      <= MAX_ITER_RST;
            cfg_reg.gravity       <= GRAVITY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_APEX_GOAL:     cfg_reg.apex_goal     <= cfg_data[30:0];
                REG_CONV_LIMIT:    cfg_reg.conv_limit    <= cfg_data[15:0];
                REG_MAX_ITER:      cfg_reg.max_iter      <= cfg_data[6:0];
                REG_GRAVITY:       cfg_reg.gravity       <= cfg_data[15:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    drc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    drc_dp #(
        .ITERATION_CAP (ITERATION_CAP)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg                (cfg_reg),
        .s_eps              (s_eps),
        .s_cos_theta        (s_cos_theta),
        .s_altitude         (s_altitude),
        .s_current_k        (s_current_k),
        .status             (status),
        .m_k_error          (m_k_error),
        .m_projected_apogee (m_projected_apogee),
        .m_converged        (m_converged)
    );

    `DRC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "still ready after accept")
    `DRC_ASSERT_NEXT(a_md_no_early_done, aclk, aresetn, cmd.md_start, !status.md_done, "muldiv done right after start")
    `DRC_ASSERT_SAME(a_finish_slot_free, aclk, aresetn, cmd.op == OP_FINISH, !m_valid || m_ready, "result overwritten")
    `DRC_ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.op == OP_FINISH, m_valid, "finished result not presented")

endmodule
